/* sv/can_frame_bridge_queue_core_assert.svh */
// Assertion helpers for the CAN frame bridge queue core.
// Each expects clk_i and rst_ni in scope.
`ifndef CAN_FRAME_BRIDGE_QUEUE_CORE_ASSERT_SVH
`define CAN_FRAME_BRIDGE_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication.
`define CFBQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cfbq: same-cycle check failed");

// Next-cycle implication.
`define CFBQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cfbq: next-cycle check failed");

`endif

/* sv/cfbq_pkg.sv */
`timescale 1ns / 1ps

package cfbq_pkg;

  localparam int unsigned QUEUE_SLOTS = 16;
  localparam int unsigned IDX_W       = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;

  localparam logic [7:0] TX_MARKER_OK = 8'd13;

  typedef enum logic [1:0] {
    FN_RX      = 2'd0,
    FN_DISCARD = 2'd1,
    FN_TX      = 2'd2,
    FN_TX_DONE = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_BAD_MRK = 3'd3,
    ST_MB_BUSY = 3'd4
  } status_e;

  typedef logic [IDX_W-1:0] idx_t;

endpackage

/* sv/can_frame_bridge_queue_core.sv */
`timescale 1ns / 1ps

// CAN frame bridge queue core. Takes one item per clock: whenever start_i is
// high it is accepted (busy_o never rises), and its single result passes
// through the input register and then the result register to the result
// ports, marked by valid_o for exactly one cycle. The receiver cannot stall,
// so results must be captured when valid_o is high. Throughput is one item
// per cycle. The receive ring holds QUEUE_SLOTS slots and at most
// QUEUE_SLOTS-1 frames; the head frame, pending flags and the active-low
// receive interrupt level are reported with every result.

`include "can_frame_bridge_queue_core_assert.svh"

module can_frame_bridge_queue_core import cfbq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  output logic        valid_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] rx_id_word_i,
  input  logic [3:0]  frame_length_i,
  input  logic [63:0] frame_data_i,
  input  logic [7:0]  tx_marker_i,
  input  logic [31:0] tx_ext_id_i,
  input  logic        mailbox_free_i,
  output logic [2:0]  status_o,
  output logic        rx_pending_o,
  output logic        rx_irq_n_o,
  output logic        tx_pending_o,
  output logic        tx_line_release_o,
  output logic [31:0] head_ext_id_o,
  output logic [3:0]  head_length_o,
  output logic [63:0] head_data_o,
  output logic        mailbox_write_o,
  output logic [31:0] mailbox_id_word_o,
  output logic [3:0]  mailbox_length_o,
  output logic [63:0] mailbox_data_o
);

  // Single pass: no item is ever refused.
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic        stg_vld_q;
  func_e       stg_func_q;
  logic [31:0] stg_rx_word_q;
  logic [3:0]  stg_len_q;
  logic [63:0] stg_data_q;
  logic [7:0]  stg_marker_q;
  logic [31:0] stg_tx_id_q;
  logic        stg_mb_free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else begin
      stg_vld_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      stg_func_q    <= func_e'(func_i);
      stg_rx_word_q <= rx_id_word_i;
      stg_len_q     <= frame_length_i;
      stg_data_q    <= frame_data_i;
      stg_marker_q  <= tx_marker_i;
      stg_tx_id_q   <= tx_ext_id_i;
      stg_mb_free_q <= mailbox_free_i;
    end
  end

  // ---------------------------------------------------------------------
  // Queue state and slot storage
  // ---------------------------------------------------------------------
  idx_t wr_q, wr_d;
  idx_t rd_q, rd_d;
  logic rx_pend_q, rx_pend_d;
  logic rx_line_q, rx_line_d;
  logic tx_pend_q, tx_pend_d;

  logic [31:0] slot_id_q   [QUEUE_SLOTS];
  logic [3:0]  slot_len_q  [QUEUE_SLOTS];
  logic [63:0] slot_data_q [QUEUE_SLOTS];

  logic        slot_we;
  logic [31:0] new_id;
  idx_t        nxt_wr;
  idx_t        nxt_rd;

  logic        status_we;
  status_e     status_d;
  logic        release_d;
  logic        mb_write_d;
  logic [31:0] mb_id_d;
  logic [3:0]  mb_len_d;
  logic [63:0] mb_data_d;

  logic        head_empty;
  logic        head_fwd;

  // Identifier sits in bits 31:3, extended flag in bit 2 moves to bit 31.
  assign new_id = {stg_rx_word_q[2], 2'b00, stg_rx_word_q[31:3]};

  assign nxt_wr = (wr_q == idx_t'(QUEUE_SLOTS - 1)) ? '0 : wr_q + idx_t'(1);
  assign nxt_rd = (rd_q == idx_t'(QUEUE_SLOTS - 1)) ? '0 : rd_q + idx_t'(1);

  always_comb begin
    wr_d       = wr_q;
    rd_d       = rd_q;
    rx_pend_d  = rx_pend_q;
    rx_line_d  = rx_line_q;
    tx_pend_d  = tx_pend_q;
    slot_we    = 1'b0;
    status_d   = ST_OK;
    release_d  = 1'b0;
    mb_write_d = 1'b0;
    mb_id_d    = '0;
    mb_len_d   = '0;
    mb_data_d  = '0;
    if (stg_vld_q) begin
      unique case (stg_func_q)
        FN_RX: begin
          if (nxt_wr == rd_q) begin
            status_d = ST_FULL;      // ring full: frame dropped
          end else begin
            slot_we   = 1'b1;
            wr_d      = nxt_wr;
            rx_pend_d = 1'b1;
            rx_line_d = 1'b0;
          end
        end
        FN_DISCARD: begin
          if (wr_q == rd_q) begin
            status_d = ST_EMPTY;
          end else begin
            rd_d      = nxt_rd;
            rx_pend_d = (wr_q != nxt_rd);
            rx_line_d = (wr_q == nxt_rd);
          end
        end
        FN_TX: begin
          if (stg_marker_q != TX_MARKER_OK) begin
            status_d  = ST_BAD_MRK;
            release_d = 1'b1;
          end else begin
            tx_pend_d = 1'b1;
            if (!stg_mb_free_q) begin
              status_d = ST_MB_BUSY;
            end else begin
              mb_write_d = 1'b1;
              // identifier << 3, extended bit 2, request bit 0
              mb_id_d    = {stg_tx_id_q[28:0], 3'b101};
              mb_len_d   = stg_len_q;
              mb_data_d  = stg_data_q;
            end
          end
        end
        FN_TX_DONE: begin
          tx_pend_d = 1'b0;
          release_d = 1'b1;
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  assign status_we = stg_vld_q;

  // Head after this step. A frame written into an empty ring becomes the
  // head in the same step, so it is forwarded around the slot store.
  assign head_empty = (wr_d == rd_d);
  assign head_fwd   = slot_we && (rd_d == wr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q      <= '0;
      rd_q      <= '0;
      rx_pend_q <= 1'b0;
      rx_line_q <= 1'b1;
      tx_pend_q <= 1'b0;
    end else begin
      wr_q      <= wr_d;
      rd_q      <= rd_d;
      rx_pend_q <= rx_pend_d;
      rx_line_q <= rx_line_d;
      tx_pend_q <= tx_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_id_q[wr_q]   <= new_id;
      slot_len_q[wr_q]  <= stg_len_q;
      slot_data_q[wr_q] <= stg_data_q;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stg_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (status_we) begin
      status_o          <= status_d;
      rx_pending_o      <= rx_pend_d;
      rx_irq_n_o        <= rx_line_d;
      tx_pending_o      <= tx_pend_d;
      tx_line_release_o <= release_d;
      if (head_empty) begin
        head_ext_id_o <= '0;
        head_length_o <= '0;
        head_data_o   <= '0;
      end else if (head_fwd) begin
        head_ext_id_o <= new_id;
        head_length_o <= stg_len_q;
        head_data_o   <= stg_data_q;
      end else begin
        head_ext_id_o <= slot_id_q[rd_d];
        head_length_o <= slot_len_q[rd_d];
        head_data_o   <= slot_data_q[rd_d];
      end
      mailbox_write_o   <= mb_write_d;
      mailbox_id_word_o <= mb_id_d;
      mailbox_length_o  <= mb_len_d;
      mailbox_data_o    <= mb_data_d;
    end
  end

  assign valid_o = valid_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `CFBQ_ASSERT_IMPL(a_pend_tracks_fill, 1'b1, rx_pend_q == (wr_q != rd_q))
  `CFBQ_ASSERT_IMPL(a_irq_inverse_pend, 1'b1, rx_line_q == !rx_pend_q)
  `CFBQ_ASSERT_NEXT(a_item_gives_result, stg_vld_q, valid_o)
  `CFBQ_ASSERT_IMPL(a_full_has_head, valid_o && (status_o == ST_FULL), rx_pending_o)
  `CFBQ_ASSERT_IMPL(a_mb_zero_no_write, valid_o && !mailbox_write_o,
                    (mailbox_id_word_o == 32'd0) && (mailbox_data_o == 64'd0))

endmodule
